// ----- rtl/core/lpbc_pkg.sv -----
package lpbc_pkg;

    // Layer numbering: sprite, four backgrounds, then the backdrop.
    localparam int unsigned NUM_LAYERS = 6;
    localparam logic [2:0]  LAYER_SPRITE = 3'd0;
    localparam logic [2:0]  LAYER_BACKDROP = 3'd5;
    localparam int unsigned FX_BIT = 5;

    // Effect mode codes.
    localparam logic [1:0] FX_NONE = 2'd0;
    localparam logic [1:0] FX_ALPHA = 2'd1;
    localparam logic [1:0] FX_BRIGHTEN = 2'd2;
    localparam logic [1:0] FX_DARKEN = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_COEF_FIRST = 3'd0;
    localparam logic [2:0] REG_COEF_SECOND = 3'd1;
    localparam logic [2:0] REG_COEF_FADE = 3'd2;
    localparam logic [2:0] REG_EFFECT_MODE = 3'd3;
    localparam logic [2:0] REG_FIRST_TARGET = 3'd4;
    localparam logic [2:0] REG_SECOND_TARGET = 3'd5;
    localparam logic [2:0] REG_WINDOW_ENABLES = 3'd6;
    localparam logic [2:0] REG_WINDOW_MASKS = 3'd7;

    localparam logic [14:0] COLOR_WHITE = 15'h7fff;
    localparam logic [14:0] COLOR_BLACK = 15'h0000;
    localparam logic [4:0]  COEF_MAX = 5'd16;
    localparam logic [4:0]  CHAN_MAX = 5'd31;

    typedef logic [14:0] color_t;

    // One pixel's layer candidates as they arrive.
    typedef struct packed {
        logic        forced_blank;
        logic [2:0]  window_hits;
        logic [18:0] sprite_pixel;
        logic [17:0] bg0_pixel;
        logic [17:0] bg1_pixel;
        logic [17:0] bg2_pixel;
        logic [17:0] bg3_pixel;
        color_t      backdrop_color;
    } pix_t;

    // Programmed blend and window settings.
    typedef struct packed {
        logic [4:0]  coef_first;
        logic [4:0]  coef_second;
        logic [4:0]  coef_fade;
        logic [1:0]  effect_mode;
        logic [5:0]  first_target_mask;
        logic [5:0]  second_target_mask;
        logic [2:0]  window_enables;
        logic [23:0] window_layer_masks;
    } cfg_t;

    function automatic logic [4:0] clamp16(input logic [4:0] v);
        return (v > COEF_MAX) ? COEF_MAX : v;
    endfunction

    // Weighted sum of two colors per channel, divided by 16 and saturated.
    function automatic color_t mix(input color_t a, input logic [4:0] wa,
                                   input color_t b, input logic [4:0] wb);
        color_t     res;
        logic [9:0] sum;
        logic [5:0] scaled;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum = 10'(a[5*ch +: 5] * wa) + 10'(b[5*ch +: 5] * wb);
            scaled = sum[9:4];
            res[5*ch +: 5] = (scaled > 6'(CHAN_MAX)) ? CHAN_MAX : scaled[4:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/lpbc_pix_if.sv -----
interface lpbc_pix_if;
    logic        valid;
    logic        ready;
    logic        forced_blank;
    logic [2:0]  window_hits;
    logic [18:0] sprite_pixel;
    logic [17:0] bg0_pixel;
    logic [17:0] bg1_pixel;
    logic [17:0] bg2_pixel;
    logic [17:0] bg3_pixel;
    logic [14:0] backdrop_color;

    modport source (
        output valid, forced_blank, window_hits, sprite_pixel,
               bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, backdrop_color,
        input  ready
    );
    modport sink (
        input  valid, forced_blank, window_hits, sprite_pixel,
               bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, backdrop_color,
        output ready
    );
endinterface

// ----- rtl/core/lpbc_color_if.sv -----
interface lpbc_color_if;
    logic        valid;
    logic        ready;
    logic [14:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink (input valid, pixel_color, output ready);
endinterface

// ----- rtl/core/lpbc_cfg_if.sv -----
interface lpbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/layer_priority_blend_compositor_core.sv -----
// Layer priority compositor with blending, one RGB555 pixel per transaction.
//
// Channels: layer_in carries one pixel's sprite and four background
// candidates, the backdrop color, window hit bits and the forced-blank
// flag. pixel_out carries the resulting RGB555 color, red in the low bits.
// cfg writes one of eight registers by index; it is always ready and must
// only be used while no pixel is in flight.
//
// An accepted input transaction passes through one input register, the
// combinational blend and one output register before the result is valid.
// Throughput is one pixel per clock while pixel_out does not stall; the rate
// is set by the single blend stage, which has no loop or shared unit.
//
// When pixel_out stalls, the output register holds its result and the
// input register can still take one more pixel; layer_in drops ready only
// when both are full. Reset empties both stages and clears every config
// register to zero, which means no windows, no effects and no blend targets.
module layer_priority_blend_compositor_core (
    input  logic      clk,
    input  logic      rst_n,
    lpbc_pix_if.sink     layer_in,
    lpbc_color_if.source pixel_out,
    lpbc_cfg_if.sink     cfg
);
    import lpbc_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   s1_valid_reg;
    logic   s1_valid_next;
    pix_t   s1_pix_reg;
    logic   s2_valid_reg;
    logic   s2_valid_next;
    color_t s2_color_reg;
    color_t blend_color;
    logic   s1_advance;
    logic   in_accept;
    pix_t   in_pix;

    // Configuration writes land in the register named by the index.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid) begin
            case (cfg.index)
                REG_COEF_FIRST:     cfg_next.coef_first = cfg.data[4:0];
                REG_COEF_SECOND:    cfg_next.coef_second = cfg.data[4:0];
                REG_COEF_FADE:      cfg_next.coef_fade = cfg.data[4:0];
                REG_EFFECT_MODE:    cfg_next.effect_mode = cfg.data[1:0];
                REG_FIRST_TARGET:   cfg_next.first_target_mask = cfg.data[5:0];
                REG_SECOND_TARGET:  cfg_next.second_target_mask = cfg.data[5:0];
                REG_WINDOW_ENABLES: cfg_next.window_enables = cfg.data[2:0];
                REG_WINDOW_MASKS:   cfg_next.window_layer_masks = cfg.data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Two-stage handshake: the input stage advances whenever the output
    // register is empty or being drained.
    assign s1_advance = !s2_valid_reg || pixel_out.ready;
    assign layer_in.ready = !s1_valid_reg || s1_advance;
    assign in_accept = layer_in.valid && layer_in.ready;

    assign in_pix.forced_blank = layer_in.forced_blank;
    assign in_pix.window_hits = layer_in.window_hits;
    assign in_pix.sprite_pixel = layer_in.sprite_pixel;
    assign in_pix.bg0_pixel = layer_in.bg0_pixel;
    assign in_pix.bg1_pixel = layer_in.bg1_pixel;
    assign in_pix.bg2_pixel = layer_in.bg2_pixel;
    assign in_pix.bg3_pixel = layer_in.bg3_pixel;
    assign in_pix.backdrop_color = layer_in.backdrop_color;

    always_comb
    begin
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        s2_valid_next = s1_advance ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_pix_reg <= in_pix;
        end
        if (s1_advance && s1_valid_reg) begin
            s2_color_reg <= blend_color;
        end
    end

    lpbc_blend u_blend (
        .pix   (s1_pix_reg),
        .cfg   (cfg_reg),
        .color (blend_color)
    );

    assign pixel_out.valid = s2_valid_reg;
    assign pixel_out.pixel_color = s2_color_reg;

    // An accepted pixel always occupies the input stage next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the input stage");

    // A blocked input stage keeps its pixel.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_pix_reg))
        else $error("input stage lost or changed a blocked pixel");

    // Ready is only high when some stage has room.
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        layer_in.ready |-> (!s1_valid_reg || !s2_valid_reg || pixel_out.ready))
        else $error("input ready while both stages are full");

    // A forced-blank pixel comes out white.
    a_blank_white: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_advance && s1_pix_reg.forced_blank
        |=> s2_valid_reg && (s2_color_reg == COLOR_WHITE))
        else $error("forced blank did not produce white");

    // A drained output with nothing behind it goes empty.
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && pixel_out.ready && !s1_valid_reg |=> !s2_valid_reg)
        else $error("output stage repeated a transaction");

endmodule

// ----- rtl/core/lpbc_blend.sv -----
module lpbc_blend (
    input  lpbc_pkg::pix_t   pix,
    input  lpbc_pkg::cfg_t   cfg,
    output lpbc_pkg::color_t color
);
    import lpbc_pkg::*;

    logic [5:0]  active;
    logic [5:0]  vis;
    logic [1:0]  pri [NUM_LAYERS];
    color_t      col [NUM_LAYERS];
    logic [5:0]  beaten_by [NUM_LAYERS];
    logic [5:0]  top_hot;
    logic [5:0]  second_hot;
    logic [2:0]  top;
    logic [2:0]  second;
    logic        translucent;
    logic        a_ok;
    logic        b_ok;
    logic [4:0]  eva;
    logic [4:0]  evb;
    logic [4:0]  evy;
    logic        use_mix;
    color_t      mix_b;
    logic [4:0]  mix_wa;
    logic [4:0]  mix_wb;
    color_t      mixed;

    // Window mask selection with fixed precedence: window 0, 1, 2, outside; no window enabled keeps all bits set.
    always_comb
    begin
        if (cfg.window_enables == 3'b000) begin
            active = 6'h3f;
        end else if (cfg.window_enables[0] && pix.window_hits[0]) begin
            active = cfg.window_layer_masks[5:0];
        end else if (cfg.window_enables[1] && pix.window_hits[1]) begin
            active = cfg.window_layer_masks[11:6];
        end else if (cfg.window_enables[2] && pix.window_hits[2]) begin
            active = cfg.window_layer_masks[17:12];
        end else begin
            active = cfg.window_layer_masks[23:18];
        end
    end

    // Unpack the candidates; the backdrop sits at priority 3, visible per mask bit 5.
    always_comb
    begin
        vis[0] = pix.sprite_pixel[17] & active[0];
        vis[1] = pix.bg0_pixel[17] & active[1];
        vis[2] = pix.bg1_pixel[17] & active[2];
        vis[3] = pix.bg2_pixel[17] & active[3];
        vis[4] = pix.bg3_pixel[17] & active[4];
        vis[5] = active[5];
        pri[0] = pix.sprite_pixel[16:15];
        pri[1] = pix.bg0_pixel[16:15];
        pri[2] = pix.bg1_pixel[16:15];
        pri[3] = pix.bg2_pixel[16:15];
        pri[4] = pix.bg3_pixel[16:15];
        pri[5] = 2'd3;
        col[0] = pix.sprite_pixel[14:0];
        col[1] = pix.bg0_pixel[14:0];
        col[2] = pix.bg1_pixel[14:0];
        col[3] = pix.bg2_pixel[14:0];
        col[4] = pix.bg3_pixel[14:0];
        col[5] = pix.backdrop_color;
    end

    // Rank every visible layer by how many visible layers outrank it.
    // A lower priority value wins, and a lower layer index breaks ties.
    always_comb
    begin
        for (int i = 0; i < NUM_LAYERS; i++) begin
            for (int j = 0; j < NUM_LAYERS; j++) begin
                beaten_by[i][j] = vis[j] && (j != i) &&
                    ((pri[j] < pri[i]) || ((pri[j] == pri[i]) && (j < i)));
            end
            top_hot[i] = vis[i] && (beaten_by[i] == 6'd0);
            second_hot[i] = vis[i] && (beaten_by[i] != 6'd0) &&
                ((beaten_by[i] & (beaten_by[i] - 6'd1)) == 6'd0);
        end
    end

    // Encode the winners; either falls back to the backdrop when missing.
    always_comb
    begin
        top = LAYER_BACKDROP;
        second = LAYER_BACKDROP;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (top_hot[i]) begin
                top = 3'(i);
            end
            if (second_hot[i]) begin
                second = 3'(i);
            end
        end
    end

    // Pick one blend path and feed a single shared mixer.
    always_comb
    begin
        eva = clamp16(cfg.coef_first);
        evb = clamp16(cfg.coef_second);
        evy = clamp16(cfg.coef_fade);
        translucent = (top == LAYER_SPRITE) && pix.sprite_pixel[18];
        a_ok = cfg.first_target_mask[top];
        b_ok = cfg.second_target_mask[second];
        use_mix = 1'b0;
        mix_wa = eva;
        mix_b = col[second];
        mix_wb = evb;
        if (active[FX_BIT]) begin
            if (translucent && b_ok) begin
                use_mix = 1'b1;
            end else begin
                case (cfg.effect_mode)
                    FX_ALPHA:
                    begin
                        use_mix = a_ok && b_ok;
                    end
                    FX_BRIGHTEN:
                    begin
                        use_mix = a_ok;
                        mix_wa = COEF_MAX - evy;
                        mix_b = COLOR_WHITE;
                        mix_wb = evy;
                    end
                    FX_DARKEN:
                    begin
                        use_mix = a_ok;
                        mix_wa = COEF_MAX - evy;
                        mix_b = COLOR_BLACK;
                        mix_wb = evy;
                    end
                    default:
                    begin
                        use_mix = 1'b0;
                    end
                endcase
            end
        end
        mixed = mix(col[top], mix_wa, mix_b, mix_wb);
    end

    // Forced blank overrides everything with white.
    always_comb
    begin
        if (pix.forced_blank) begin
            color = COLOR_WHITE;
        end else if (use_mix) begin
            color = mixed;
        end else begin
            color = col[top];
        end
    end

endmodule
